### rtl/cmo_pkg.sv
// Shared widths, register indexes and the configuration bundle for the
// colour matrix offset unit. No dependencies.
package cmo_pkg;

    localparam int CHAN_W   = 8;
    localparam int COEFF_W  = 16;
    localparam int ROW_W    = 3 * COEFF_W;
    localparam int OFFSET_W = 20;
    localparam int PROD_W   = COEFF_W + CHAN_W + 1;
    localparam int ACC_W    = PROD_W + 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_ROW   = 2'd0,
        REG_GREEN_ROW = 2'd1,
        REG_BLUE_ROW  = 2'd2,
        REG_OFFSET    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [ROW_W-1:0]    red_row;
        logic [ROW_W-1:0]    green_row;
        logic [ROW_W-1:0]    blue_row;
        logic [OFFSET_W-1:0] offset;
    } cfg_t;

endpackage

### rtl/rgb_color_matrix_offset_unit.sv
// RGBA colour matrix with common offset, three channel datapaths plus
// alpha/last side band. Depends on cmo_pkg, cmo_cfg_regs, cmo_row.
// Throughput one pixel per cycle while the output is not stalled, through the
// three-stage multiply / sum / saturate pipeline.
// A finished beat held by output stall holds the whole pipeline. Reset clears
// the valid bits and loads the identity matrix with zero offset.
module rgb_color_matrix_offset_unit #(
    parameter int COEFF_FRAC_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cmo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cmo_pkg::ROW_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cmo_pkg::CHAN_W-1:0]      red_in,
    input  logic [cmo_pkg::CHAN_W-1:0]      green_in,
    input  logic [cmo_pkg::CHAN_W-1:0]      blue_in,
    input  logic [cmo_pkg::CHAN_W-1:0]      alpha_in,
    input  logic                            last_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cmo_pkg::CHAN_W-1:0]      red_out,
    output logic [cmo_pkg::CHAN_W-1:0]      green_out,
    output logic [cmo_pkg::CHAN_W-1:0]      blue_out,
    output logic [cmo_pkg::CHAN_W-1:0]      alpha_out,
    output logic                            last_out
);
    import cmo_pkg::*;

    localparam int DEPTH = 3;

    cfg_t cfg;
    logic adv;

    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic [CHAN_W-1:0] alpha_reg [DEPTH];
    logic [DEPTH-1:0]  last_reg;

    cmo_cfg_regs #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cmo_row #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_red (
        .clk(clk), .adv(adv), .row(cfg.red_row), .offset(cfg.offset),
        .r(red_in), .g(green_in), .b(blue_in), .result(red_out)
    );

    cmo_row #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_green (
        .clk(clk), .adv(adv), .row(cfg.green_row), .offset(cfg.offset),
        .r(red_in), .g(green_in), .b(blue_in), .result(green_out)
    );

    cmo_row #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_blue (
        .clk(clk), .adv(adv), .row(cfg.blue_row), .offset(cfg.offset),
        .r(red_in), .g(green_in), .b(blue_in), .result(blue_out)
    );

    // pipeline moves unless a finished beat is held at the output
    assign adv      = !(valid_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        valid_next = {valid_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alpha_reg[0] <= alpha_in;
            last_reg[0]  <= last_in;
            for (int i = 1; i < DEPTH; i++)
            begin
                alpha_reg[i] <= alpha_reg[i-1];
                last_reg[i]  <= last_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign alpha_out = alpha_reg[DEPTH-1];
    assign last_out  = last_reg[DEPTH-1];

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall |=> out_valid)
        else $error("accepted beat did not reach the output in three cycles");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !valid_reg[DEPTH-2]) |=> !out_valid)
        else $error("output beat repeated after being taken");

    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid && !in_stall) |=> !valid_reg[0])
        else $error("first stage valid without an input beat");
`endif

endmodule

### rtl/cmo_cfg_regs.sv
// Configuration register file: three coefficient rows and the common offset.
// Depends on cmo_pkg.
module cmo_cfg_regs #(
    parameter int COEFF_FRAC_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cmo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cmo_pkg::ROW_W-1:0]           cfg_data,
    output cmo_pkg::cfg_t                       cfg
);
    import cmo_pkg::*;

    localparam logic [ROW_W-1:0] ONE = ROW_W'(1) << COEFF_FRAC_BITS;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_RED_ROW:   cfg_next.red_row   = cfg_data;
                REG_GREEN_ROW: cfg_next.green_row = cfg_data;
                REG_BLUE_ROW:  cfg_next.blue_row  = cfg_data;
                REG_OFFSET:    cfg_next.offset    = cfg_data[OFFSET_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_row   <= ONE;
            cfg_reg.green_row <= ONE << COEFF_W;
            cfg_reg.blue_row  <= ONE << (2 * COEFF_W);
            cfg_reg.offset    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/cmo_row.sv
// Datapath for one output channel: products, sum with offset, saturation,
// one register stage each. Depends on cmo_pkg.
module cmo_row #(
    parameter int COEFF_FRAC_BITS = 12
) (
    input  logic                            clk,
    input  logic                            adv,
    input  logic [cmo_pkg::ROW_W-1:0]       row,
    input  logic [cmo_pkg::OFFSET_W-1:0]    offset,
    input  logic [cmo_pkg::CHAN_W-1:0]      r,
    input  logic [cmo_pkg::CHAN_W-1:0]      g,
    input  logic [cmo_pkg::CHAN_W-1:0]      b,
    output logic [cmo_pkg::CHAN_W-1:0]      result
);
    import cmo_pkg::*;

    localparam int SAT_LO = COEFF_FRAC_BITS + CHAN_W;

    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [CHAN_W-1:0]        res_reg;
    logic [CHAN_W-1:0]        res_next;

    always_comb
    begin
        prod_next[0] = $signed(row[COEFF_W-1:0])           * $signed({1'b0, r});
        prod_next[1] = $signed(row[2*COEFF_W-1:COEFF_W])   * $signed({1'b0, g});
        prod_next[2] = $signed(row[3*COEFF_W-1:2*COEFF_W]) * $signed({1'b0, b});
    end

    always_comb
    begin
        acc_next = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2])
                 + $signed(ACC_W'(offset));
    end

    // negative to zero, 256.0 and above to full scale, fraction dropped
    always_comb
    begin
        if (acc_reg[ACC_W-1])
            res_next = '0;
        else if (|acc_reg[ACC_W-2:SAT_LO])
            res_next = '1;
        else
            res_next = acc_reg[SAT_LO-1:COEFF_FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

endmodule

### tb/rgb_color_matrix_offset_unit_test.sv
// Self-checking testbench for rgb_color_matrix_offset_unit: directed and random pixel
// beats under several matrix and offset settings, checked against a built-in predictor.
// Depends on cmo_pkg and rgb_color_matrix_offset_unit.
`timescale 1ns / 100ps

module rgb_color_matrix_offset_unit_test;

    import cmo_pkg::*;

    localparam int FRAC_BITS = 12;
    localparam logic [CHAN_W-1:0] CHANNEL_MAX = 8'hFF;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES = 10;
    localparam int PIXELS_PER_PHASE = 75;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              last_flag;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CHAN_W-1:0] red_in = '0;
    logic [CHAN_W-1:0] green_in = '0;
    logic [CHAN_W-1:0] blue_in = '0;
    logic [CHAN_W-1:0] alpha_in = '0;
    logic last_in = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic last_out;

    pixel_t pending_pixels[$];
    pixel_t expected_pixels[$];
    logic [ROW_W-1:0] row_model [3];
    logic [OFFSET_W-1:0] offset_model;
    logic in_taken = 1'b0;
    logic allow_idle = 1'b1;
    logic quiet = 1'b0;
    int in_gap = 0;
    int out_gap = 0;
    int fail_count = 0;
    int idle_cycles = 0;

    rgb_color_matrix_offset_unit #(
        .COEFF_FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .red_in(red_in),
        .green_in(green_in),
        .blue_in(blue_in),
        .alpha_in(alpha_in),
        .last_in(last_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red_out(red_out),
        .green_out(green_out),
        .blue_out(blue_out),
        .alpha_out(alpha_out),
        .last_out(last_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offset plus weighted sum, floored, clamped to 0..255
    function automatic logic [CHAN_W-1:0] weigh_channel(logic [ROW_W-1:0] row, pixel_t px);
        longint acc;
        acc = longint'(offset_model);
        acc = acc + longint'($signed(row[15:0])) * longint'(px.red);
        acc = acc + longint'($signed(row[31:16])) * longint'(px.green);
        acc = acc + longint'($signed(row[47:32])) * longint'(px.blue);
        if (acc < 0)
            return '0;
        acc = acc >>> FRAC_BITS;
        if (acc > longint'(CHANNEL_MAX))
            return CHANNEL_MAX;
        return acc[CHAN_W-1:0];
    endfunction

    function automatic pixel_t filter_pixel(pixel_t px);
        pixel_t res;
        res = px;
        res.red = weigh_channel(row_model[REG_RED_ROW], px);
        res.green = weigh_channel(row_model[REG_GREEN_ROW], px);
        res.blue = weigh_channel(row_model[REG_BLUE_ROW], px);
        return res;
    endfunction

    function automatic logic [COEFF_W-1:0] random_weight();
        case ($urandom_range(0, 5))
            0: return COEFF_W'($urandom);
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return '0;
            default: return COEFF_W'(int'($urandom_range(0, 16'h1C00)) - 16'h0800);
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] random_offset();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return OFFSET_W'($urandom);
            2: return OFFSET_W'($urandom_range(0, 20'h40000));
            default: return '1;
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CHANNEL_MAX;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [ROW_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_OFFSET)
            offset_model = value[OFFSET_W-1:0];
        else
            row_model[idx] = value;
    endtask

    task automatic write_all_rows(input logic [COEFF_W-1:0] weight);
        write_reg(REG_RED_ROW, {3{weight}});
        write_reg(REG_GREEN_ROW, {3{weight}});
        write_reg(REG_BLUE_ROW, {3{weight}});
    endtask

    task automatic add_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a,
                             input logic l);
        pending_pixels.push_back('{red: r, green: g, blue: b, alpha: a, last_flag: l});
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (allow_idle && !quiet && $urandom_range(0, 5) == 0)
            begin
                in_gap = $urandom_range(0, 2);
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() != 0)
            begin
                pixel_t px;
                px = pending_pixels.pop_front();
                red_in <= px.red;
                green_in <= px.green;
                blue_in <= px.blue;
                alpha_in <= px.alpha;
                last_in <= px.last_flag;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else if (rst_n && allow_idle && !quiet && $urandom_range(0, 5) == 0)
        begin
            out_gap = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_pixels.push_back(filter_pixel('{red: red_in, green: green_in,
                blue: blue_in, alpha: alpha_in, last_flag: last_in}));
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{red: red_out, green: green_out, blue: blue_out, alpha: alpha_out,
                    last_flag: last_out};
            if (expected_pixels.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected beat r=%0d g=%0d b=%0d a=%0d last=%0b", $time,
                         got.red, got.green, got.blue, got.alpha, got.last_flag);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    $display("%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d last=%0b,",
                             $time, want.red, want.green, want.blue, want.alpha,
                             want.last_flag,
                             " got r=%0d g=%0d b=%0d a=%0d last=%0b",
                             got.red, got.green, got.blue, got.alpha, got.last_flag);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL rgb_color_matrix_offset_unit");
            $finish;
        end
    end

    initial
    begin
        row_model[REG_RED_ROW] = ROW_W'(1) << FRAC_BITS;
        row_model[REG_GREEN_ROW] = ROW_W'(1) << (FRAC_BITS + COEFF_W);
        row_model[REG_BLUE_ROW] = ROW_W'(1) << (FRAC_BITS + 2 * COEFF_W);
        offset_model = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // identity after reset
        add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        add_pixel(8'h55, 8'hAA, 8'h0F, 8'hF0, 1'b0);
        add_pixel(8'hAA, 8'h55, 8'hF0, 8'h0F, 1'b1);
        add_pixel(8'h01, 8'h80, 8'hFE, 8'h07, 1'b0);
        drain();

        // largest weights, offset beyond its nominal range, upper data bits dropped
        write_all_rows(16'h7FFF);
        write_reg(REG_OFFSET, '1);
        add_pixel(8'h00, 8'h00, 8'h00, 8'h33, 1'b0);
        add_pixel(8'h01, 8'h00, 8'h00, 8'hCC, 1'b1);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h80, 1'b0);
        drain();

        // most negative weights: the larger sums fall below zero
        write_all_rows(16'h8000);
        add_pixel(8'h00, 8'h00, 8'h00, 8'h01, 1'b0);
        add_pixel(8'h01, 8'h00, 8'h00, 8'h02, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h04, 1'b1);
        add_pixel(8'h00, 8'h00, 8'h01, 8'h08, 1'b0);
        drain();

        // luma weights with half-unit offset, fractional parts dropped
        write_reg(REG_RED_ROW, {16'h01D3, 16'h0964, 16'h04C9});
        write_reg(REG_GREEN_ROW, {16'h01D3, 16'h0964, 16'h04C9});
        write_reg(REG_BLUE_ROW, {16'h01D3, 16'h0964, 16'h04C9});
        write_reg(REG_OFFSET, ROW_W'(20'h00800));
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h10, 1'b0);
        add_pixel(8'd100, 8'd150, 8'd200, 8'h20, 1'b0);
        add_pixel(8'h00, 8'h00, 8'h00, 8'h40, 1'b1);
        add_pixel(8'd37, 8'd201, 8'd88, 8'h7F, 1'b0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            quiet = (phase == RANDOM_PHASES - 1);
            allow_idle = ($urandom_range(0, 3) != 0);
            write_reg(REG_RED_ROW, {random_weight(), random_weight(), random_weight()});
            write_reg(REG_GREEN_ROW, {random_weight(), random_weight(), random_weight()});
            write_reg(REG_BLUE_ROW, {random_weight(), random_weight(), random_weight()});
            write_reg(REG_OFFSET, {28'($urandom), random_offset()});
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
                add_pixel(random_level(), random_level(), random_level(), CHAN_W'($urandom),
                          $urandom_range(0, 15) == 0);
            drain();
        end

        if (fail_count == 0)
            $display("PASS rgb_color_matrix_offset_unit");
        else
            $display("FAIL rgb_color_matrix_offset_unit");
        $finish;
    end

endmodule
